### rtl/cbpa_pkg.sv
// package for the contiguous block pool allocator
// holds widths, codes, payload structs and helper functions; no dependencies
`default_nettype none

package cbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W      = CNT_W + 1;

    localparam int BB_W     = 17;
    localparam int NB_W     = 7;
    localparam int REQ_W    = 23;
    localparam int OFF_W    = 22;
    localparam int STAT_W   = 2;
    localparam int START_W  = 6;
    localparam int RUN_W    = 7;
    localparam int FREE_W   = 7;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;
    localparam int DIVD_W   = REQ_W;

    localparam logic [BB_W-1:0] BB_RESET = BB_W'(64);
    localparam logic [NB_W-1:0] NB_RESET = NB_W'(64);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_OFF  = 2'd2,
        ST_NOT_BUSY = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] byte_offset;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] start_block;
        logic [RUN_W-1:0]   run_blocks;
        logic [FREE_W-1:0]  free_blocks;
    } out_t;

    // block count with zero taken as one and saturation at the pool size
    function automatic logic [CNT_W-1:0] eff_blocks(input logic [NB_W-1:0] nb);
        logic [CNT_W-1:0] r;
        if (nb == '0) begin
            r = CNT_W'(1);
        end else if (32'(nb) > MAX_BLOCKS) begin
            r = CNT_W'(MAX_BLOCKS);
        end else begin
            r = CNT_W'(nb);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cbpa_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/cbpa_div.sv
// restoring divider, one quotient bit per cycle
// uses cbpa_pkg for operand widths
`default_nettype none

module cbpa_div
    import cbpa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [BB_W-1:0]   divisor,
    output logic                   done,
    output logic      [DIVD_W-1:0] quotient,
    output logic      [BB_W-1:0]   remainder
);

    localparam int ITER_W = $clog2(DIVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [BB_W-1:0]   rem_reg, rem_next;
    logic [BB_W-1:0]   dsr_reg, dsr_next;
    logic [BB_W:0]     trial;
    logic [BB_W:0]     diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[BB_W-1:0] : trial[BB_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], ge};
            if (cnt_reg == ITER_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/contiguous_block_pool_allocator_core.sv
// contiguous block pool allocator, first fit over a block state ram
// uses cbpa_pkg, cbpa_ram (block state per entry) and cbpa_div (size and offset division)
// allocate divides the size, then scans block states one block a cycle and writes
//   the run one block a cycle; free divides the offset, reads the start entry,
//   checks the run and clears it one block a cycle; the result is then registered
// one request at a time
// reset and every blocks_in_use write start a ram clearing pass over all 64 entries
`default_nettype none

module contiguous_block_pool_allocator_core
    import cbpa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIV  = 10'b0000000010,
        S_SCAN = 10'b0000000100,
        S_AWR  = 10'b0000001000,
        S_FRD  = 10'b0000010000,
        S_FLEN = 10'b0000100000,
        S_FCHK = 10'b0001000000,
        S_FCLR = 10'b0010000000,
        S_RESP = 10'b0100000000,
        S_CLR  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [BB_W-1:0]  block_bytes_reg, block_bytes_next;
    logic [NB_W-1:0]  blocks_reg, blocks_next;
    logic [CNT_W-1:0] free_reg, free_next;
    in_t              in_reg, in_next;

    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] wcnt_reg, wcnt_next;

    logic [STAT_W-1:0]  rs_status_reg, rs_status_next;
    logic [START_W-1:0] rs_start_reg, rs_start_next;
    logic [RUN_W-1:0]   rs_run_reg, rs_run_next;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic [CNT_W-1:0]  n_eff;
    logic [BB_W-1:0]   bb_eff;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;
    logic [BB_W-1:0]   div_r;
    logic [DIVD_W:0]   need_wide;

    logic             ram_we, ram_re;
    logic [BLK_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    logic             ent_busy;
    logic [CNT_W-1:0] ent_len;
    logic [CNT_W-1:0] run_inc;

    assign n_eff    = eff_blocks(blocks_reg);
    assign bb_eff   = (block_bytes_reg == '0) ? BB_W'(1) : block_bytes_reg;
    assign ent_busy = ram_rdata[CNT_W];
    assign ent_len  = ram_rdata[CNT_W-1:0];
    assign run_inc  = run_reg + 1'b1;

    assign need_wide = {1'b0, div_q} + {{DIVD_W{1'b0}}, div_r != '0};

    assign s_ready      = state_reg == S_IDLE;
    assign div_start    = s_valid && s_ready;
    assign div_dividend = (s_data.operation == OP_FREE) ?
                          {{(DIVD_W-OFF_W){1'b0}}, s_data.byte_offset} : s_data.request_bytes;

    cbpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bb_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    cbpa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [CNT_W:0] fend;
        state_next       = state_reg;
        block_bytes_next = block_bytes_reg;
        blocks_next      = blocks_reg;
        free_next        = free_reg;
        in_next          = in_reg;
        addr_next        = addr_reg;
        pend_next        = 1'b0;
        pidx_next        = pidx_reg;
        run_next         = run_reg;
        start_next       = start_reg;
        need_next        = need_reg;
        end_next         = end_reg;
        wr_next          = wr_reg;
        wcnt_next        = wcnt_reg;
        rs_status_next   = rs_status_reg;
        rs_start_next    = rs_start_reg;
        rs_run_next      = rs_run_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = wr_reg[BLK_W-1:0];
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = addr_reg[BLK_W-1:0];
        fend             = {1'b0, start_reg} + {1'b0, ent_len};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    rs_start_next = '0;
                    rs_run_next   = '0;
                    if (in_reg.operation == OP_ALLOC) begin
                        if (in_reg.request_bytes == '0 || free_reg == '0 ||
                            need_wide > (DIVD_W+1)'(free_reg)) begin
                            rs_status_next = ST_NO_SPACE;
                            state_next     = S_RESP;
                        end else begin
                            need_next  = need_wide[CNT_W-1:0];
                            addr_next  = '0;
                            run_next   = '0;
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (div_q >= DIVD_W'(n_eff) || div_r != '0) begin
                            rs_status_next = ST_BAD_OFF;
                            state_next     = S_RESP;
                        end else begin
                            start_next = div_q[CNT_W-1:0];
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_SCAN: begin
                // reads are issued one ahead of the flags being examined
                if (addr_reg < n_eff) begin
                    ram_re    = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = addr_reg;
                end
                if (pend_reg) begin
                    if (!ent_busy) begin
                        if (run_reg == '0) begin
                            start_next = pidx_reg;
                        end
                        run_next = run_inc;
                        if (run_inc == need_reg) begin
                            pend_next  = 1'b0;
                            wr_next    = (run_reg == '0) ? pidx_reg : start_reg;
                            wcnt_next  = '0;
                            state_next = S_AWR;
                        end
                    end else begin
                        run_next = '0;
                    end
                end else if (addr_reg >= n_eff) begin
                    rs_status_next = ST_NO_SPACE;
                    rs_start_next  = '0;
                    rs_run_next    = '0;
                    state_next     = S_RESP;
                end
            end
            S_AWR: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, (wcnt_reg == '0) ? need_reg : CNT_W'(0)};
                wr_next   = wr_reg + 1'b1;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == '0) begin
                    start_next = wr_reg;
                end
                if (wcnt_reg + 1'b1 == need_reg) begin
                    free_next      = free_reg - need_reg;
                    rs_status_next = ST_OK;
                    rs_start_next  = START_W'((wcnt_reg == '0) ? wr_reg : start_reg);
                    rs_run_next    = RUN_W'(need_reg);
                    state_next     = S_RESP;
                end
            end
            S_FRD: begin
                ram_re     = 1'b1;
                ram_raddr  = start_reg[BLK_W-1:0];
                state_next = S_FLEN;
            end
            S_FLEN: begin
                if (fend > {1'b0, n_eff}) begin
                    rs_status_next = ST_BAD_OFF;
                    state_next     = S_RESP;
                end else if (ent_len == '0) begin
                    rs_status_next = ST_NOT_BUSY;
                    state_next     = S_RESP;
                end else begin
                    need_next  = ent_len;
                    end_next   = fend[CNT_W-1:0];
                    addr_next  = start_reg;
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                if (addr_reg < end_reg) begin
                    ram_re    = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = addr_reg;
                end
                if (pend_reg) begin
                    if (!ent_busy) begin
                        pend_next      = 1'b0;
                        rs_status_next = ST_NOT_BUSY;
                        state_next     = S_RESP;
                    end else if (pidx_reg == end_reg - 1'b1) begin
                        pend_next  = 1'b0;
                        wr_next    = start_reg;
                        wcnt_next  = '0;
                        state_next = S_FCLR;
                    end
                end
            end
            S_FCLR: begin
                ram_we    = 1'b1;
                wr_next   = wr_reg + 1'b1;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg + 1'b1 == need_reg) begin
                    free_next      = free_reg + need_reg;
                    rs_status_next = ST_OK;
                    rs_start_next  = START_W'(start_reg);
                    rs_run_next    = RUN_W'(need_reg);
                    state_next     = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = rs_status_reg;
                    m_data_next.start_block  = rs_start_reg;
                    m_data_next.run_blocks   = rs_run_reg;
                    m_data_next.free_blocks  = FREE_W'(free_reg);
                    state_next               = S_IDLE;
                end
            end
            S_CLR: begin
                ram_we  = 1'b1;
                wr_next = wr_reg + 1'b1;
                if (wr_reg == CNT_W'(MAX_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase

        if (cfg_we) begin
            priority case (cfg_index)
                CFG_BLOCK_BYTES: begin
                    block_bytes_next = cfg_wdata[BB_W-1:0];
                end
                CFG_BLOCKS_IN_USE: begin
                    blocks_next = cfg_wdata[NB_W-1:0];
                    free_next   = eff_blocks(cfg_wdata[NB_W-1:0]);
                    wr_next     = '0;
                    state_next  = S_CLR;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLR;
            block_bytes_reg <= BB_RESET;
            blocks_reg      <= NB_RESET;
            free_reg        <= eff_blocks(NB_RESET);
            wr_reg          <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            block_bytes_reg <= block_bytes_next;
            blocks_reg      <= blocks_next;
            free_reg        <= free_next;
            wr_reg          <= wr_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
        in_reg        <= in_next;
        addr_reg      <= addr_next;
        pidx_reg      <= pidx_next;
        run_reg       <= run_next;
        start_reg     <= start_next;
        need_reg      <= need_next;
        end_reg       <= end_next;
        wcnt_reg      <= wcnt_next;
        rs_status_reg <= rs_status_next;
        rs_start_reg  <= rs_start_next;
        rs_run_reg    <= rs_run_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_reg) <= MAX_BLOCKS)
        else $error("free count above pool size");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_AWR || state_reg == S_FCLR || state_reg == S_CLR))
        else $error("ram write outside a write pass");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV || state_reg == S_CLR))
        else $error("divider result with no request waiting");

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && m_valid_reg && !m_ready && !cfg_we) |=> state_reg == S_RESP)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire
